/* hw/rtl/pcc_pkg.sv */
// Shared types and constants of the clamped PID controller.
// Used by every RTL module and by the port checker; depends on nothing.
package pcc_pkg;

  localparam int GainW  = 16;
  localparam int LimW   = 16;
  localparam int OmaxW  = 15;
  localparam int DriveW = 16;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  typedef enum logic [1:0] {
    OP_UPDATE  = 2'd0,
    OP_CLR_INT = 2'd1,
    OP_CLR_ALL = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    MODE_P   = 2'd0,
    MODE_PI  = 2'd1,
    MODE_PD  = 2'd2,
    MODE_PID = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_INTEGRAL_MAX = 3'd3,
    REG_INTEGRAL_MIN = 3'd4,
    REG_OUTPUT_MAX   = 3'd5,
    REG_OUTPUT_MIN   = 3'd6,
    REG_TERM_MODE    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [GainW-1:0] gain_p;
    logic signed [GainW-1:0] gain_i;
    logic signed [GainW-1:0] gain_d;
    logic signed [LimW-1:0]  integral_max;
    logic signed [LimW-1:0]  integral_min;
    logic [OmaxW-1:0]        output_max;
    logic signed [LimW-1:0]  output_min;
    mode_e                   term_mode;
  } cfg_t;

  // Control of the word held between the term stage and the accumulate stage.
  typedef struct packed {
    logic    valid;
    opcode_e op;
  } stage_ctrl_t;

endpackage

/* hw/rtl/pcc_cfg.sv */
// APB-style register file holding gains, limits and the term mode.
// Depends on pcc_pkg.
module pcc_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pcc_pkg::AddrW-1:0]   paddr,
  input  logic [pcc_pkg::DataW-1:0]   pwdata,
  output logic [pcc_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output pcc_pkg::cfg_t               cfg_o
);
  import pcc_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p       <= '0;
      cfg_q.gain_i       <= '0;
      cfg_q.gain_d       <= '0;
      cfg_q.integral_max <= '0;
      cfg_q.integral_min <= '0;
      cfg_q.output_max   <= '1;
      cfg_q.output_min   <= {1'b1, {(LimW-1){1'b0}}};
      cfg_q.term_mode    <= MODE_PID;
    end else if (wr_en) begin
      case (idx)
        REG_GAIN_P:       cfg_q.gain_p       <= pwdata[GainW-1:0];
        REG_GAIN_I:       cfg_q.gain_i       <= pwdata[GainW-1:0];
        REG_GAIN_D:       cfg_q.gain_d       <= pwdata[GainW-1:0];
        REG_INTEGRAL_MAX: cfg_q.integral_max <= pwdata[LimW-1:0];
        REG_INTEGRAL_MIN: cfg_q.integral_min <= pwdata[LimW-1:0];
        REG_OUTPUT_MAX:   cfg_q.output_max   <= pwdata[OmaxW-1:0];
        REG_OUTPUT_MIN:   cfg_q.output_min   <= pwdata[LimW-1:0];
        REG_TERM_MODE:    cfg_q.term_mode    <= mode_e'(pwdata[1:0]);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_GAIN_P:       prdata[GainW-1:0] = cfg_q.gain_p;
      REG_GAIN_I:       prdata[GainW-1:0] = cfg_q.gain_i;
      REG_GAIN_D:       prdata[GainW-1:0] = cfg_q.gain_d;
      REG_INTEGRAL_MAX: prdata[LimW-1:0]  = cfg_q.integral_max;
      REG_INTEGRAL_MIN: prdata[LimW-1:0]  = cfg_q.integral_min;
      REG_OUTPUT_MAX:   prdata[OmaxW-1:0] = cfg_q.output_max;
      REG_OUTPUT_MIN:   prdata[LimW-1:0]  = cfg_q.output_min;
      REG_TERM_MODE:    prdata[1:0]       = cfg_q.term_mode;
      default:          prdata            = '0;
    endcase
  end

endmodule

/* hw/rtl/pcc_terms.sv */
// Term stage: error, error change and the three gain products, registered.
// Holds the last error. Depends on pcc_pkg.
module pcc_terms #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pcc_pkg::cfg_t                     cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        opcode_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    setpoint_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    feedback_i,
  input  logic                              take_i,
  output pcc_pkg::stage_ctrl_t              ctrl_o,
  output logic signed [SAMPLE_WIDTH+16:0]   p_term_o,
  output logic signed [SAMPLE_WIDTH+16:0]   i_step_o,
  output logic signed [SAMPLE_WIDTH+17:0]   d_term_o
);
  import pcc_pkg::*;

  stage_ctrl_t                    ctrl_q;
  logic signed [SAMPLE_WIDTH:0]   prev_err_q;
  logic signed [SAMPLE_WIDTH:0]   err;
  logic signed [SAMPLE_WIDTH+1:0] derr;
  logic signed [GainW-1:0]        kp, ki, kd;
  logic signed [SAMPLE_WIDTH+16:0] p_d, i_d, p_q, i_q;
  logic signed [SAMPLE_WIDTH+17:0] d_d, d_q;
  logic                           accept;
  opcode_e                        op;

  assign op     = opcode_e'(opcode_i);
  assign kp     = cfg_i.gain_p;
  assign ki     = cfg_i.gain_i;
  assign kd     = cfg_i.gain_d;
  assign err    = (SAMPLE_WIDTH+1)'(setpoint_i) - (SAMPLE_WIDTH+1)'(feedback_i);
  assign derr   = (SAMPLE_WIDTH+2)'(err) - (SAMPLE_WIDTH+2)'(prev_err_q);
  assign p_d    = (SAMPLE_WIDTH+17)'(kp) * (SAMPLE_WIDTH+17)'(err);
  assign i_d    = (SAMPLE_WIDTH+17)'(ki) * (SAMPLE_WIDTH+17)'(err);
  assign d_d    = (SAMPLE_WIDTH+18)'(kd) * (SAMPLE_WIDTH+18)'(derr);

  // The held word moves on only when the accumulate stage takes it.
  assign in_stall_o = ctrl_q.valid & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign ctrl_o   = ctrl_q;
  assign p_term_o = p_q;
  assign i_step_o = i_q;
  assign d_term_o = d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q.valid <= 1'b0;
      ctrl_q.op    <= OP_UPDATE;
      prev_err_q   <= '0;
    end else if (accept) begin
      ctrl_q.op <= op;
      case (op)
        OP_UPDATE: begin
          ctrl_q.valid <= 1'b1;
          prev_err_q   <= err;
        end
        OP_CLR_INT: begin
          ctrl_q.valid <= 1'b1;
        end
        OP_CLR_ALL: begin
          ctrl_q.valid <= 1'b1;
          prev_err_q   <= '0;
        end
        default: begin
          ctrl_q.valid <= 1'b0;
        end
      endcase
    end else if (take_i) begin
      ctrl_q.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_q <= p_d;
      i_q <= i_d;
      d_q <= d_d;
    end
  end

endmodule

/* hw/rtl/pcc_accum.sv */
// Accumulate stage: clamped integral, mode sum, shift, output clamp and
// the output register. Depends on pcc_pkg.
module pcc_accum #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pcc_pkg::cfg_t                     cfg_i,
  input  pcc_pkg::stage_ctrl_t              ctrl_i,
  input  logic signed [SAMPLE_WIDTH+16:0]   p_term_i,
  input  logic signed [SAMPLE_WIDTH+16:0]   i_step_i,
  input  logic signed [SAMPLE_WIDTH+17:0]   d_term_i,
  output logic                              take_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [pcc_pkg::DriveW-1:0] drive_o
);
  import pcc_pkg::*;

  localparam int IntW  = 16 + GAIN_FRAC_BITS;
  localparam int StepW = SAMPLE_WIDTH + 17;
  localparam int AccW  = ((IntW > StepW) ? IntW : StepW) + 1;
  localparam int DW    = SAMPLE_WIDTH + 18;
  localparam int SumW  = ((DW > IntW) ? DW : IntW) + 2;

  logic signed [IntW-1:0]   integ_q, integ_new;
  logic signed [AccW-1:0]   acc_sum, acc_lo, acc_hi, acc_clamped;
  logic signed [SumW-1:0]   sum, shifted, lo_ext, hi_ext, res;
  logic signed [LimW:0]     lo, hi;
  logic                     out_valid_q;
  logic signed [DriveW-1:0] drive_q;

  // Integral in Q.GAIN_FRAC_BITS, clamped with the lower limit tested first.
  assign acc_sum     = AccW'(integ_q) + AccW'(i_step_i);
  assign acc_lo      = AccW'(cfg_i.integral_min) <<< GAIN_FRAC_BITS;
  assign acc_hi      = AccW'(cfg_i.integral_max) <<< GAIN_FRAC_BITS;
  assign acc_clamped = (acc_sum < acc_lo) ? acc_lo :
                       (acc_sum > acc_hi) ? acc_hi : acc_sum;
  assign integ_new   = IntW'(acc_clamped);

  always_comb begin
    case (cfg_i.term_mode)
      MODE_P:   sum = SumW'(p_term_i);
      MODE_PI:  sum = SumW'(p_term_i) + SumW'(integ_new);
      MODE_PD:  sum = SumW'(p_term_i) + SumW'(d_term_i);
      MODE_PID: sum = SumW'(p_term_i) + SumW'(integ_new) + SumW'(d_term_i);
      default:  sum = SumW'(p_term_i);
    endcase
  end

  assign shifted = sum >>> GAIN_FRAC_BITS;
  assign hi      = $signed({2'b00, cfg_i.output_max});
  assign lo      = (cfg_i.term_mode == MODE_PID) ? (LimW+1)'(cfg_i.output_min) : -hi;
  assign lo_ext  = SumW'(lo);
  assign hi_ext  = SumW'(hi);
  assign res     = (shifted < lo_ext) ? lo_ext :
                   (shifted > hi_ext) ? hi_ext : shifted;

  // Clear items never wait for the output register.
  assign take_o = ctrl_i.valid &
                  ((ctrl_i.op != OP_UPDATE) | ~out_valid_q | ~out_stall_i);

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        case (ctrl_i.op)
          OP_UPDATE:  integ_q <= integ_new;
          OP_CLR_INT: integ_q <= '0;
          OP_CLR_ALL: integ_q <= '0;
          default: begin
          end
        endcase
      end
      if (take_o && ctrl_i.op == OP_UPDATE) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && ctrl_i.op == OP_UPDATE) begin
      drive_q <= res[DriveW-1:0];
    end
  end

endmodule

/* hw/rtl/pid_controller_clamped_top.sv */
// Top level of the clamped positional PID controller.
// Instantiates pcc_cfg, pcc_terms and pcc_accum; depends on pcc_pkg.
//
//   port group  direction  handshake                  payload
//   -----------------------------------------------------------------------
//   input       in         in_valid_i / in_stall_o    opcode_i, setpoint_i,
//                                                     feedback_i
//   output      out        out_valid_o / out_stall_i  drive_o
//   config      in         psel, penable, pwrite      paddr, pwdata, prdata
//
// One word is accepted every cycle unless the input stalls. An update word
// passes the term register (error and the three gain products) and then the
// output register. Clear words pass the same two stages, term and accumulate,
// but produce no output word. Reset clears the last error, the integral, both
// valid flags and the registers to their documented values. While the output
// word is stalled, the term stage still fills, and clear words keep draining
// past it; the input stalls only when an update word waits behind a stalled
// output word.
//
// The integral and the last error are the only state carried from word to
// word. The last error is updated as a word enters the term stage and the
// integral as a word leaves it, so back-to-back words see each other's
// state without bubbles.
module pid_controller_clamped_top #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        opcode_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    setpoint_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    feedback_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [pcc_pkg::DriveW-1:0] drive_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pcc_pkg::AddrW-1:0]         paddr,
  input  logic [pcc_pkg::DataW-1:0]         pwdata,
  output logic [pcc_pkg::DataW-1:0]         prdata,
  output logic                              pready
);
  import pcc_pkg::*;

  cfg_t                            cfg;
  stage_ctrl_t                     ctrl;
  logic                            take;
  logic signed [SAMPLE_WIDTH+16:0] p_term;
  logic signed [SAMPLE_WIDTH+16:0] i_step;
  logic signed [SAMPLE_WIDTH+17:0] d_term;

  // Register file; the user must change configuration only while the pipeline is idle; it is unchecked.
  pcc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // First stage: error, error change and products, one multiplier deep.
  pcc_terms #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_terms (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .setpoint_i (setpoint_i),
    .feedback_i (feedback_i),
    .take_i     (take),
    .ctrl_o     (ctrl),
    .p_term_o   (p_term),
    .i_step_o   (i_step),
    .d_term_o   (d_term)
  );

  // Second stage: integral update, mode sum, scaling, clamp, output register.
  pcc_accum #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .ctrl_i      (ctrl),
    .p_term_i    (p_term),
    .i_step_i    (i_step),
    .d_term_i    (d_term),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_o     (drive_o)
  );

endmodule

/* hw/rtl/pcc_checker.sv */
// Port-level checker for the clamped PID controller, bound to the top level.
// Depends on pcc_pkg and pid_controller_clamped_top.
module pcc_port_props (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [1:0]                        opcode_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [pcc_pkg::DriveW-1:0] drive_o
);
  import pcc_pkg::*;

  // A held output word keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_o))
    else $error("stalled output word changed or vanished");

  // The input only stalls behind a stalled output word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the output side was free");

  // A new output word follows an accepted update word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && !in_stall_o && opcode_i == OP_UPDATE, 2))
    else $error("output word without an update word");

  // With a free output side and an empty output register, an accepted update reaches the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && opcode_i == OP_UPDATE && !out_valid_o ##1 !out_stall_i
      |=> out_valid_o)
    else $error("update word was lost");

endmodule

bind pid_controller_clamped_top pcc_port_props u_pcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .opcode_i    (opcode_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .drive_o     (drive_o)
);

/* dv/pcc_checker.sv */
`timescale 1ns / 100ps
// Port checker of the clamped PID controller: follows the register writes,
// predicts every drive word and compares it with the word the block sends.
// Depends on pcc_pkg only; it watches the ports and never drives them.
module pcc_checker #(
  parameter int FracBits = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [1:0]                        opcode_i,
  input  logic signed [15:0]                setpoint_i,
  input  logic signed [15:0]                feedback_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [pcc_pkg::DriveW-1:0] drive_i,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pcc_pkg::AddrW-1:0]         paddr,
  input  logic [pcc_pkg::DataW-1:0]         pwdata,
  input  logic                              pready,
  output int                                fail_count_o,
  output int                                pending_o
);
  import pcc_pkg::*;

  cfg_t                     cfg;
  logic signed [16:0]       last_err;
  logic signed [23:0]       integ_q8;
  logic signed [DriveW-1:0] drive_due_q[$];
  int                       errors = 0;

  assign fail_count_o = errors;

  task automatic flag_error(input string msg);
    $display("%0t ns: ERROR: %s", $time, msg);
    errors++;
  endtask

  // The lower limit is tested first, so inverted limits give it only below it.
  function automatic longint limit_lo_first(input longint v, input longint lo,
                                            input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Applies one accepted word to the controller state; returns 1 when it
  // produces a drive word.
  function automatic bit pid_step(input logic [1:0] op,
                                  input logic signed [15:0] sp,
                                  input logic signed [15:0] fb,
                                  output logic signed [DriveW-1:0] drv);
    longint err, derr, p_term, d_term, acc, sum, lo, hi;
    drv = '0;
    if (op == OP_CLR_INT || op == OP_CLR_ALL) begin
      integ_q8 = '0;
      if (op == OP_CLR_ALL) last_err = '0;
      return 1'b0;
    end
    if (op != OP_UPDATE) return 1'b0;

    err      = longint'(sp) - longint'(fb);
    derr     = err - longint'(last_err);
    last_err = err[16:0];

    p_term = longint'($signed(cfg.gain_p)) * err;
    d_term = longint'($signed(cfg.gain_d)) * derr;
    acc    = longint'(integ_q8) + longint'($signed(cfg.gain_i)) * err;
    lo     = longint'($signed(cfg.integral_min)) <<< FracBits;
    hi     = longint'($signed(cfg.integral_max)) <<< FracBits;
    acc    = limit_lo_first(acc, lo, hi);
    integ_q8 = acc[23:0];

    case (cfg.term_mode)
      MODE_P:  sum = p_term;
      MODE_PI: sum = p_term + acc;
      MODE_PD: sum = p_term + d_term;
      default: sum = p_term + acc + d_term;
    endcase
    sum = sum >>> FracBits;

    hi  = longint'(cfg.output_max);
    lo  = (cfg.term_mode == MODE_PID) ? longint'($signed(cfg.output_min)) : -hi;
    drv = DriveW'(limit_lo_first(sum, lo, hi));
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic signed [DriveW-1:0] drv;
    if (!rst_ni) begin
      cfg            = '0;
      cfg.output_max = '1;
      cfg.output_min = 16'sh8000;
      cfg.term_mode  = MODE_PID;
      last_err       = '0;
      integ_q8       = '0;
      drive_due_q.delete();
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[AddrW-1:2]))
          REG_GAIN_P:       cfg.gain_p       = pwdata[15:0];
          REG_GAIN_I:       cfg.gain_i       = pwdata[15:0];
          REG_GAIN_D:       cfg.gain_d       = pwdata[15:0];
          REG_INTEGRAL_MAX: cfg.integral_max = pwdata[15:0];
          REG_INTEGRAL_MIN: cfg.integral_min = pwdata[15:0];
          REG_OUTPUT_MAX:   cfg.output_max   = pwdata[OmaxW-1:0];
          REG_OUTPUT_MIN:   cfg.output_min   = pwdata[15:0];
          REG_TERM_MODE:    cfg.term_mode    = mode_e'(pwdata[1:0]);
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (drive_due_q.size() == 0) begin
          flag_error($sformatf("drive word %0d with no update pending", drive_i));
        end else begin
          drv = drive_due_q.pop_front();
          if (drive_i !== drv) begin
            flag_error($sformatf("drive %0d, expected %0d", drive_i, drv));
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (pid_step(opcode_i, setpoint_i, feedback_i, drv)) drive_due_q.push_back(drv);
      end

      pending_o <= drive_due_q.size();
    end
  end

endmodule

/* dv/tb_pid_controller_clamped_top.sv */
`timescale 1ns / 100ps
// Testbench top of the clamped PID controller: clock, reset, register writes,
// word stimulus, output stalls and the verdict.
// Depends on pcc_pkg, pcc_checker and the RTL of pid_controller_clamped_top.
module tb_pid_controller_clamped_top;
  import pcc_pkg::*;

  // Opcode 3 has no meaning; the block must ignore it.
  localparam logic [1:0] OpUnused = 2'd3;

  localparam int PhaseCount   = 10;
  localparam int PhaseWords   = 125;
  // The phase in which the output side holds off long enough to fill the block.
  localparam int HoldPhase    = 5;
  localparam int HoldCycles   = 300;
  // Cycles with no accepted word, no register access and no reset before the
  // run is declared hung. The longest legal quiet stretch is the hold above.
  localparam int QuietLimit   = 4000;
  // Two pipeline stages; clear words give no output, so wait this long after
  // the last drive word before touching the registers.
  localparam int SettleCycles = 4;

  logic                     clk      = 1'b0;
  logic                     rst_n    = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               opcode   = OP_UPDATE;
  logic signed [15:0]       setpoint = '0;
  logic signed [15:0]       feedback = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DriveW-1:0] drive;
  logic                     psel    = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite  = 1'b0;
  logic [AddrW-1:0]         paddr   = '0;
  logic [DataW-1:0]         pwdata  = '0;
  logic [DataW-1:0]         prdata;
  logic                     pready;

  int fail_count;
  int pending;
  int quiet_cycles = 0;
  // Knobs set by the stimulus; the output-side process reads rx_idle_en and hold_len.
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  int hold_len   = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pid_controller_clamped_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .opcode_i   (opcode),
    .setpoint_i (setpoint),
    .feedback_i (feedback),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .drive_o    (drive),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  pcc_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .opcode_i    (opcode),
    .setpoint_i  (setpoint),
    .feedback_i  (feedback),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .drive_i     (drive),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Watchdog. Any accepted word or register access restarts the count, so it
  // only fires when the block stops moving altogether.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("** pid_controller_clamped_top: FAILED **");
      $finish;
    end
  end

  // Output side. Each pass picks a stretch of random length, stalled or
  // not, so stalls land on every phase of the pipeline. A requested hold
  // takes priority and is counted here, independent of the sender.
  initial begin : receiver
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_len > 0) begin
        n        = hold_len;
        hold_len = 0;
        out_stall <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 16);
        out_stall <= 1'b1;
      end else begin
        n = $urandom_range(1, 16);
        out_stall <= 1'b0;
      end
      repeat (n) @(posedge clk);
    end
  end

  // One register write: setup phase, access phase, then an idle phase with psel
  // low so that back-to-back writes never assign psel twice in one step.
  // The bits above the register's width carry noise; the block must drop them.
  task automatic write_reg(input reg_idx_e idx, input int value, input int width);
    logic [DataW-1:0] keep;
    keep = (DataW'(1) << width) - 1;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom & ~keep) | (DataW'(value) & keep);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Lowers valid and waits until every drive word has left the block, then
  // lets the pipeline settle so that trailing clear words are gone as well.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Registers are only written with the block idle, so every setting starts
  // with a drain.
  task automatic set_cfg(input int kp, input int ki, input int kd, input int imax,
                         input int imin, input int omax, input int omin,
                         input mode_e mode);
    drain();
    write_reg(REG_GAIN_P,       kp,   GainW);
    write_reg(REG_GAIN_I,       ki,   GainW);
    write_reg(REG_GAIN_D,       kd,   GainW);
    write_reg(REG_INTEGRAL_MAX, imax, LimW);
    write_reg(REG_INTEGRAL_MIN, imin, LimW);
    write_reg(REG_OUTPUT_MAX,   omax, OmaxW);
    write_reg(REG_OUTPUT_MIN,   omin, LimW);
    write_reg(REG_TERM_MODE,    int'(mode), 2);
  endtask

  // Offers one word and returns at the edge that accepts it. An optional gap
  // before it drops valid for a burst; valid is never dropped and raised in
  // the same step.
  task automatic send_word(input logic [1:0] op, input logic signed [15:0] sp,
                           input logic signed [15:0] fb);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    setpoint <= sp;
    feedback <= fb;
    do @(posedge clk); while (in_stall);
  endtask

  // Gains: the two extremes, zero, any 16-bit value, or a moderate value
  // that keeps the output out of saturation.
  function automatic int rand_gain();
    case ($urandom_range(0, 7))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return int'($signed(16'($urandom)));
      default: return int'($urandom_range(0, 1024)) - 512;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 4))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh7fff;
          1:       return 16'sh8000;
          2:       return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      1, 2:    return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 600)) - 300);
    endcase
  endfunction

  initial begin : stimulus
    int          kp, ki, kd, ihi, ilo, ohi, olo, t, pick, fb_next;
    mode_e       mode;
    logic [1:0]  op;
    logic signed [15:0] sp_base, fb_track;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---------------- Directed part, no idling on either side ----------------

    // Reset settings: full PID with all gains zero, so the drive is zero.
    send_word(OP_UPDATE, 16'sd100, 16'sd40);

    // Unity P gain with small I and negative D. The first two words give the
    // largest error of either sign and the largest jump in error.
    set_cfg(256, 64, -128, 100, -100, 32767, -32768, MODE_PID);
    send_word(OP_UPDATE, 16'sh7fff, 16'sh8000);
    send_word(OP_UPDATE, 16'sh8000, 16'sh7fff);
    send_word(OP_UPDATE, 16'sd0, 16'sd0);
    // Clearing the integral keeps the last error; clearing all drops both.
    send_word(OP_CLR_INT, 16'sd0, 16'sd0);
    send_word(OP_UPDATE, 16'sd500, 16'sd0);
    send_word(OP_CLR_ALL, 16'sd0, 16'sd0);
    send_word(OP_UPDATE, 16'sd500, 16'sd0);
    // The unused opcode must not touch the state nor produce a word.
    send_word(OpUnused, 16'sh7fff, 16'sh8000);
    send_word(OP_UPDATE, -16'sd1, 16'sd0);

    // Largest positive and largest negative gains with the widest limits.
    set_cfg(32767, 32767, 32767, 32767, -32768, 32767, -32768, MODE_PID);
    send_word(OP_UPDATE, 16'sh7fff, 16'sh8000);
    send_word(OP_UPDATE, 16'sh8000, 16'sh7fff);
    set_cfg(-32768, -32768, -32768, 32767, -32768, 32767, -32768, MODE_PID);
    send_word(OP_UPDATE, 16'sh7fff, 16'sh8000);
    send_word(OP_UPDATE, 16'sh8000, 16'sh7fff);

    // Inverted integral limits and inverted PID output limits: the lower
    // limit wins wherever a value falls below it.
    set_cfg(256, 256, 0, -50, 50, 10, 100, MODE_PID);
    send_word(OP_UPDATE, 16'sd1000, 16'sd0);
    send_word(OP_UPDATE, -16'sd1000, 16'sd0);
    send_word(OP_UPDATE, 16'sd0, 16'sd0);

    // Symmetric modes: output_max of zero pins the drive, then P, PI and PD
    // with a PID-only lower limit that must be ignored.
    set_cfg(300, 100, 200, 1000, -1000, 0, -32768, MODE_P);
    send_word(OP_UPDATE, 16'sd1000, 16'sd0);
    set_cfg(300, 100, 200, 1000, -1000, 20000, 5, MODE_P);
    send_word(OP_UPDATE, 16'sd1000, 16'sd0);
    send_word(OP_UPDATE, -16'sd3000, 16'sd0);
    set_cfg(300, 100, 200, 1000, -1000, 20000, 5, MODE_PI);
    send_word(OP_UPDATE, 16'sd1000, 16'sd0);
    send_word(OP_UPDATE, -16'sd3000, 16'sd0);
    set_cfg(300, 100, 200, 1000, -1000, 20000, 5, MODE_PD);
    send_word(OP_UPDATE, 16'sd1000, 16'sd0);
    send_word(OP_UPDATE, -16'sd3000, 16'sd0);

    // ---------------- Random part ----------------
    // Each phase picks a fresh setting, then runs a loop that mostly tracks a
    // fixed setpoint with a feedback that closes in on it, so the integral
    // builds up and decays as in real use, with random samples and clear
    // words mixed in. The last phase runs without any idling.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      kp  = rand_gain();
      ki  = rand_gain();
      kd  = rand_gain();
      ihi = int'($urandom_range(0, 4000));
      ilo = -int'($urandom_range(0, 4000));
      if ($urandom_range(0, 5) == 0) begin
        ihi = 32767;
        ilo = -32768;
      end
      if ($urandom_range(0, 7) == 0) begin
        t   = ihi;
        ihi = ilo;
        ilo = t;
      end
      case ($urandom_range(0, 9))
        0:       ohi = 0;
        1, 2:    ohi = 32767;
        default: ohi = int'($urandom_range(0, 8000));
      endcase
      olo = ($urandom_range(0, 5) == 0) ? -32768 : -int'($urandom_range(0, 8000));
      if ($urandom_range(0, 7) == 0) begin
        olo = ohi + 1 + int'($urandom_range(0, 100));
        if (olo > 32767) olo = 32767;
      end
      mode = mode_e'($urandom_range(0, 3));
      set_cfg(kp, ki, kd, ihi, ilo, ohi, olo, mode);

      tx_idle_en = (ph != PhaseCount - 1);
      rx_idle_en = (ph != PhaseCount - 1);
      // The output side freezes for a long stretch while words keep coming,
      // so the pipeline fills and the input stalls.
      if (ph == HoldPhase) hold_len = HoldCycles;

      sp_base  = rand_sample();
      fb_track = rand_sample();
      for (int n = 0; n < PhaseWords; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          op = OP_CLR_INT;
        end else if (pick < 10) begin
          op = OP_CLR_ALL;
        end else if (pick < 13) begin
          op = OpUnused;
        end else begin
          op = OP_UPDATE;
        end
        if ($urandom_range(0, 9) < 7) begin
          fb_next  = int'(fb_track) + (int'(sp_base) - int'(fb_track)) / 8 +
                     int'($urandom_range(0, 64)) - 32;
          fb_track = 16'(fb_next);
          send_word(op, sp_base, fb_track);
        end else begin
          send_word(op, rand_sample(), rand_sample());
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("** pid_controller_clamped_top: PASSED **");
    end else begin
      $display("** pid_controller_clamped_top: FAILED **");
    end
    $finish;
  end

endmodule

/* pid_controller_clamped_top.f */
hw/rtl/pcc_pkg.sv
hw/rtl/pcc_cfg.sv
hw/rtl/pcc_terms.sv
hw/rtl/pcc_accum.sv
hw/rtl/pid_controller_clamped_top.sv
hw/rtl/pcc_checker.sv
dv/pcc_checker.sv
dv/tb_pid_controller_clamped_top.sv
